>>> design/txc_pkg.sv
// Shared definitions for the text console writer: field widths, character codes,
// operation codes and the controller state type. No dependencies.

package txc_pkg;

	localparam int FUNC_W = 3;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int BYTE_W = 8;
	localparam int CELL_W = 2 * BYTE_W;

	localparam int NUM_COLUMNS_DEF = 80;
	localparam int NUM_ROWS_DEF    = 25;

	localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0a;

	localparam logic [FUNC_W-1:0] FN_PRINT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PLACE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SET   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_SCROLL,
		S_FILL
	} state_t;

endpackage

>>> design/text_console_writer.sv
// Text console writer: screen memory of character/attribute cells plus a cursor.
// Depends on txc_pkg.
//
//  Channel | Handshake                  | Beat contents
//  --------+----------------------------+------------------------------------------------
//  command | start, busy (take: start & !busy) | func, column, row, char_code, attribute
//  result  | done (one-cycle strobe)    | cursor_column, cursor_row, cell_char,
//          |                            | cell_attribute, scrolled, ignored
//
// Place, set cursor, unused codes and a print that does not scroll return their result
// in the cycle after the command beat; busy never rises for them.
// A read returns its result after the registered memory read and the S_READ state.
// Clear and a scrolling print walk the whole screen memory through its single write
// port, busy high throughout. After reset the block clears the screen memory with busy
// high. The receiver cannot stall; each result is shown for exactly one cycle.

module text_console_writer #(
	parameter int NUM_COLUMNS = txc_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = txc_pkg::NUM_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [txc_pkg::FUNC_W-1:0]  func,
	input  logic [txc_pkg::COL_W-1:0]   column,
	input  logic [txc_pkg::ROW_W-1:0]   row,
	input  logic [txc_pkg::BYTE_W-1:0]  char_code,
	input  logic [txc_pkg::BYTE_W-1:0]  attribute,
	output logic                        done,
	output logic [txc_pkg::COL_W-1:0]   cursor_column,
	output logic [txc_pkg::ROW_W-1:0]   cursor_row,
	output logic [txc_pkg::BYTE_W-1:0]  cell_char,
	output logic [txc_pkg::BYTE_W-1:0]  cell_attribute,
	output logic                        scrolled,
	output logic                        ignored
);
	import txc_pkg::*;

	localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	// The walk counter must also hold CELL_COUNT itself, the end mark of a scroll.
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);

	localparam logic [ADDR_W-1:0] NC_A       = ADDR_W'(NUM_COLUMNS);
	localparam logic [COL_W-1:0]  NC_C       = COL_W'(NUM_COLUMNS);
	localparam logic [ROW_W-1:0]  NR_R       = ROW_W'(NUM_ROWS);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(NUM_ROWS - 1);
	localparam logic [CNT_W-1:0]  CNT_NC     = CNT_W'(NUM_COLUMNS);
	localparam logic [CNT_W-1:0]  CNT_END    = CNT_W'(CELL_COUNT);
	localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(CELL_COUNT - 1);
	localparam logic [CNT_W-1:0]  CNT_BOTTOM = CNT_W'(CELL_COUNT - NUM_COLUMNS);

	// Screen memory: one cell per entry, {attribute, character}.
	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;

	state_t state_q, state_d;

	// Cursor kept as column and row so that no division is needed.
	logic [COL_W-1:0]  cx_q;
	logic [ROW_W-1:0]  cy_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] fill_attr_q;
	logic              done_q;
	logic [BYTE_W-1:0] cell_char_q;
	logic [BYTE_W-1:0] cell_attr_q;
	logic              scrolled_q;
	logic              ignored_q;

	// Copy pipeline of the scroll: the cell read in one cycle is written one row up in the next.
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic              accept;
	logic              in_range;
	logic [ADDR_W-1:0] target_addr;
	logic [ADDR_W-1:0] cursor_addr;

	// Print cursor arithmetic.
	logic [COL_W-1:0]  px;
	logic [ROW_W-1:0]  py;
	logic              wrap;

	// Memory port controls.
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	assign accept      = start && (state_q == S_IDLE);
	assign in_range    = (column < NC_C) && (row < NR_R);
	assign target_addr = ADDR_W'(row) * NC_A + ADDR_W'(column);
	assign cursor_addr = ADDR_W'(cy_q) * NC_A + ADDR_W'(cx_q);

	// A newline goes to column 0 of the next row; any other byte advances one column and
	// wraps at the end of the row. Moving past the last row means a scroll.
	always_comb begin
		logic [COL_W-1:0] nx;
		logic [ROW_W-1:0] ny;
		if (char_code == NEWLINE_CHAR) begin
			nx = '0;
			ny = cy_q + ROW_W'(1);
		end else begin
			nx = cx_q + COL_W'(1);
			ny = cy_q;
		end
		if (nx >= NC_C) begin
			nx = '0;
			ny = ny + ROW_W'(1);
		end
		px   = nx;
		wrap = (ny >= NR_R);
		py   = wrap ? LAST_ROW : ny;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (cnt_q == CNT_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (func)
						FN_PRINT: if (wrap) state_d = S_SCROLL;
						FN_CLEAR: state_d = S_FILL;
						FN_READ:  state_d = S_READ;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_READ: state_d = S_IDLE;
			S_SCROLL: begin
				if (cnt_q == CNT_END) state_d = S_FILL;
			end
			S_FILL: begin
				if (cnt_q == CNT_LAST) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the controller: handshake and memory port controls.
	always_comb begin
		busy  = (state_q != S_IDLE);
		we    = 1'b0;
		waddr = cursor_addr;
		wdata = {attribute, char_code};
		re    = 1'b0;
		raddr = target_addr;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = cnt_q[ADDR_W-1:0];
				wdata = {BYTE_W'(0), SPACE_CHAR};
			end
			S_IDLE: begin
				if (accept) begin
					case (func)
						FN_PRINT: begin
							we    = (char_code != NEWLINE_CHAR);
							waddr = cursor_addr;
						end
						FN_PLACE: begin
							we    = in_range;
							waddr = target_addr;
						end
						FN_READ: re = in_range;
						default: we = 1'b0;
					endcase
				end
			end
			S_SCROLL: begin
				we    = wr_pend_s1;
				waddr = wr_addr_s1;
				wdata = rdata_q;
				re    = (cnt_q != CNT_END);
				raddr = cnt_q[ADDR_W-1:0];
			end
			S_FILL: begin
				we    = 1'b1;
				waddr = cnt_q[ADDR_W-1:0];
				wdata = {fill_attr_q, SPACE_CHAR};
			end
			default: we = 1'b0;
		endcase
	end

	// Screen memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			cx_q       <= '0;
			cy_q       <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				S_INIT: cnt_q <= cnt_q + CNT_W'(1);
				S_IDLE: begin
					if (accept) begin
						case (func)
							FN_PRINT: begin
								cx_q   <= px;
								cy_q   <= py;
								cnt_q  <= CNT_NC;
								done_q <= !wrap;
							end
							FN_SET: begin
								if (in_range) begin
									cx_q <= column;
									cy_q <= row;
								end
								done_q <= 1'b1;
							end
							FN_CLEAR: begin
								cx_q  <= '0;
								cy_q  <= '0;
								cnt_q <= '0;
							end
							FN_READ: done_q <= 1'b0;
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_READ: done_q <= 1'b1;
				S_SCROLL: begin
					if (cnt_q != CNT_END) begin
						wr_pend_s1 <= 1'b1;
						cnt_q      <= cnt_q + CNT_W'(1);
					end else begin
						// The last copy drains this cycle; then the bottom row is filled.
						wr_pend_s1 <= 1'b0;
						cnt_q      <= CNT_BOTTOM;
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) done_q <= 1'b1;
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_SCROLL) begin
			wr_addr_s1 <= ADDR_W'(cnt_q - CNT_NC);
		end
		if (state_q == S_READ && !ignored_q) begin
			cell_char_q <= rdata_q[BYTE_W-1:0];
			cell_attr_q <= rdata_q[CELL_W-1:BYTE_W];
		end
		if (accept) begin
			fill_attr_q <= attribute;
			cell_char_q <= '0;
			cell_attr_q <= '0;
			scrolled_q  <= (func == FN_PRINT) && wrap;
			ignored_q   <= ((func == FN_PLACE) || (func == FN_SET) || (func == FN_READ))
				&& !in_range;
		end
	end

	assign done           = done_q;
	assign cursor_column  = cx_q;
	assign cursor_row     = cy_q;
	assign cell_char      = cell_char_q;
	assign cell_attribute = cell_attr_q;
	assign scrolled       = scrolled_q;
	assign ignored        = ignored_q;

endmodule

>>> design/txc_checker.sv
// Port-level checks for the text console writer, attached by a bind statement.
// Depends on txc_pkg and the text_console_writer module.

module txc_checker #(
	parameter int NUM_COLUMNS = txc_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = txc_pkg::NUM_ROWS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [txc_pkg::FUNC_W-1:0]  func,
	input logic [txc_pkg::COL_W-1:0]   column,
	input logic [txc_pkg::ROW_W-1:0]   row,
	input logic [txc_pkg::BYTE_W-1:0]  char_code,
	input logic [txc_pkg::BYTE_W-1:0]  attribute,
	input logic                        done,
	input logic [txc_pkg::COL_W-1:0]   cursor_column,
	input logic [txc_pkg::ROW_W-1:0]   cursor_row,
	input logic [txc_pkg::BYTE_W-1:0]  cell_char,
	input logic [txc_pkg::BYTE_W-1:0]  cell_attribute,
	input logic                        scrolled,
	input logic                        ignored
);
	import txc_pkg::*;

	logic unused_ok;
	assign unused_ok = ^{func, column, row, char_code, attribute, cell_char, cell_attribute};

	// A result beat always finishes the operation: the block is ready again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	// A taken command either answers at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy)) else $error("command beat lost");

	// At every result beat the cursor is on the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((cursor_row < ROW_W'(NUM_ROWS)) && (cursor_column < COL_W'(NUM_COLUMNS))))
		else $error("cursor off screen");

	// After a scroll the cursor sits on the bottom row.
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> (cursor_row == ROW_W'(NUM_ROWS - 1)))
		else $error("scroll left cursor off the bottom row");

	// A scroll only comes from a print, which has no position to reject.
	a_scroll_not_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(scrolled && ignored)) else $error("scrolled and ignored together");

endmodule

bind text_console_writer txc_checker #(
	.NUM_COLUMNS(NUM_COLUMNS),
	.NUM_ROWS(NUM_ROWS)
) u_txc_checker (.*);
